// ----- rtl/core/pra_pkg.sv -----
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types and constants of the page reference count allocator.
// ----------------------------------------------------------------------------
package pra_pkg;

    localparam int MODE_W      = 2;
    localparam int PAGE_W      = 13;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 8;
    localparam int REG_W       = 14;
    localparam int CFG_INDEX_W = 2;

    // Reference counts are packed several to a memory row.
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    localparam int DEF_MAX_PAGES = 8192;

    localparam logic [REG_W-1:0]   PAGE_COUNT_RESET = 14'd8192;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT      = 8'd254;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHARE   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_PAGE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_COUNT = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_OOM   = 3'd1,
        ST_RANGE = 3'd2,
        ST_NOREF = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ACC_RD,
        S_ACC_EVAL,
        S_DONE
    } state_t;

endpackage

// ----- rtl/core/page_refcount_allocator.sv -----
// ----------------------------------------------------------------------------
// page_refcount_allocator
// Physical page frame allocator with an 8-bit reference count per page,
// kept eight counts to a row in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, mode, page_number     | request in
//  out     | out_valid, out_ready, result_page, status,| result out
//          | ref_count, free_count                    |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | write in
//
// Release and share pass through S_ACC_RD (count row read) and S_ACC_EVAL to
// S_DONE; S_ACC_EVAL is skipped when the page lies outside the window or the
// mode is undefined. Allocate reads the row of first_page, then checks one RAM
// row (eight pages) at a time upward, fetching the next row on the single read
// port while the current one is checked, until a free page or the last row.
// After reset a clearing pass writes zero to every row (MAX_PAGES/8 rows, 1024
// by default), during which no request is accepted. A new request is accepted
// while the previous result waits in the output register; a stalled output holds the block in its final state.
// ----------------------------------------------------------------------------
module page_refcount_allocator #(
    parameter int MAX_PAGES = pra_pkg::DEF_MAX_PAGES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pra_pkg::MODE_W-1:0]     mode,
    input  logic [pra_pkg::PAGE_W-1:0]     page_number,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pra_pkg::PAGE_W-1:0]     result_page,
    output logic [pra_pkg::STATUS_W-1:0]   status,
    output logic [pra_pkg::COUNT_W-1:0]    ref_count,
    output logic [pra_pkg::REG_W-1:0]      free_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pra_pkg::REG_W-1:0]      cfg_data
);

    import pra_pkg::*;

    localparam int ROWS   = (MAX_PAGES + LANES - 1) / LANES;
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = (RW + LANE_W + 1 > REG_W) ? RW + LANE_W + 1 : REG_W;
    localparam int WORD_W = LANES * COUNT_W;

    state_t state_reg, state_next;

    logic [REG_W-1:0]    first_page_reg;
    logic [REG_W-1:0]    page_count_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       used_reg;
    logic [PAGE_W-1:0]   res_page_reg;
    status_t             res_status_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                out_valid_reg;
    logic [PAGE_W-1:0]   result_page_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  ref_count_reg;
    logic [REG_W-1:0]    free_count_reg;

    logic                ram_wr_en;
    logic [RW-1:0]       ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [RW-1:0]       ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    logic                in_accept;
    logic                res_load;
    logic [PAGE_W-1:0]   res_page_c;
    status_t             res_status_c;
    logic [COUNT_W-1:0]  res_count_c;
    logic                used_inc;
    logic                used_dec;
    logic                out_load;

    logic [CW-1:0]       top_c;
    logic [CW-1:0]       first_c;
    logic [CW-1:0]       page_c;
    logic [CW-1:0]       usable_c;
    logic [CW-1:0]       free_c;
    logic                in_window;
    logic                alloc_empty;
    logic                last_row;
    logic [CW-1:0]       lane_idx [LANES];
    logic [LANES-1:0]    lane_free;
    logic                found;
    logic [LANE_W-1:0]   found_lane;
    logic [COUNT_W-1:0]  acc_count;

    pra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Window arithmetic.
    assign top_c     = (CW'(page_count_reg) < CW'(MAX_PAGES)) ? CW'(page_count_reg)
                                                              : CW'(MAX_PAGES);
    assign first_c   = CW'(first_page_reg);
    assign page_c    = CW'(page_reg);
    assign in_window = (page_c >= first_c) && (page_c < top_c);
    assign alloc_empty = (first_c >= top_c);
    assign usable_c  = (top_c > first_c) ? top_c - first_c : '0;
    assign free_c    = (usable_c > used_reg) ? usable_c - used_reg : '0;
    assign last_row  = (CW'({row_reg, LANE_W'(0)}) + CW'(LANES)) >= top_c;
    assign acc_count = ram_rd_data[page_reg[LANE_W-1:0]*COUNT_W +: COUNT_W];

    // Lowest free page of the row currently on the RAM output.
    always_comb
    begin
        found      = 1'b0;
        found_lane = '0;
        for (int l = 0; l < LANES; l++)
        begin
            lane_idx[l]  = CW'({row_reg, LANE_W'(l)});
            lane_free[l] = (ram_rd_data[l*COUNT_W +: COUNT_W] == '0)
                           && (lane_idx[l] >= first_c) && (lane_idx[l] < top_c);
        end
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (lane_free[l])
            begin
                found      = 1'b1;
                found_lane = LANE_W'(l);
            end
        end
    end

    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (row_reg == RW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (mode == MODE_ALLOC) ? S_ALLOC_RD : S_ACC_RD;
                end
            end
            S_ALLOC_RD:
            begin
                state_next = alloc_empty ? S_DONE : S_ALLOC_CHK;
            end
            S_ALLOC_CHK:
            begin
                if (found || last_row)
                begin
                    state_next = S_DONE;
                end
            end
            S_ACC_RD:
            begin
                if (((mode_reg != MODE_RELEASE) && (mode_reg != MODE_SHARE)) || !in_window)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ACC_EVAL;
                end
            end
            S_ACC_EVAL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM control and result formation.
    always_comb
    begin
        logic [LANE_W-1:0]  lane_sel;
        logic [COUNT_W-1:0] new_count;

        lane_sel     = page_reg[LANE_W-1:0];
        new_count    = '0;
        in_ready     = 1'b0;
        row_next     = row_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = row_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = row_reg;
        ram_wr_data  = ram_rd_data;
        res_load     = 1'b0;
        res_page_c   = page_reg;
        res_status_c = ST_OK;
        res_count_c  = '0;
        used_inc     = 1'b0;
        used_dec     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '0;
                row_next    = (row_reg == RW'(ROWS - 1)) ? '0 : row_reg + RW'(1);
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                row_next = first_c[RW+LANE_W-1:LANE_W];
            end
            S_ALLOC_RD:
            begin
                if (alloc_empty)
                begin
                    res_load     = 1'b1;
                    res_page_c   = '0;
                    res_status_c = ST_OOM;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                end
            end
            S_ALLOC_CHK:
            begin
                if (found)
                begin
                    lane_sel    = found_lane;
                    new_count   = COUNT_W'(1);
                    ram_wr_en   = 1'b1;
                    ram_wr_data[lane_sel*COUNT_W +: COUNT_W] = new_count;
                    used_inc    = 1'b1;
                    res_load    = 1'b1;
                    res_page_c  = lane_idx[found_lane][PAGE_W-1:0];
                    res_count_c = new_count;
                end
                else if (last_row)
                begin
                    res_load     = 1'b1;
                    res_page_c   = '0;
                    res_status_c = ST_OOM;
                end
                else
                begin
                    // Fetch the next row while this one is being checked.
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = row_reg + RW'(1);
                    row_next    = row_reg + RW'(1);
                end
            end
            S_ACC_RD:
            begin
                ram_rd_addr = page_c[RW+LANE_W-1:LANE_W];
                if (((mode_reg != MODE_RELEASE) && (mode_reg != MODE_SHARE)) || !in_window)
                begin
                    res_load     = 1'b1;
                    res_status_c = ST_RANGE;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                end
            end
            S_ACC_EVAL:
            begin
                ram_wr_addr = page_c[RW+LANE_W-1:LANE_W];
                res_load    = 1'b1;
                if (acc_count == '0)
                begin
                    res_status_c = ST_NOREF;
                end
                else if (mode_reg == MODE_RELEASE)
                begin
                    new_count   = acc_count - COUNT_W'(1);
                    ram_wr_en   = 1'b1;
                    ram_wr_data[lane_sel*COUNT_W +: COUNT_W] = new_count;
                    used_dec    = (new_count == '0) && (used_reg != '0);
                    res_count_c = new_count;
                end
                else if (acc_count >= COUNT_LIMIT)
                begin
                    res_status_c = ST_SAT;
                    res_count_c  = acc_count;
                end
                else
                begin
                    new_count   = acc_count + COUNT_W'(1);
                    ram_wr_en   = 1'b1;
                    ram_wr_data[lane_sel*COUNT_W +: COUNT_W] = new_count;
                    res_count_c = new_count;
                end
            end
            S_DONE:
            begin
                ram_rd_en = 1'b0;
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            row_reg        <= '0;
            used_reg       <= '0;
            first_page_reg <= '0;
            page_count_reg <= PAGE_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            if (used_inc)
            begin
                used_reg <= used_reg + CW'(1);
            end
            else if (used_dec)
            begin
                used_reg <= used_reg - CW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FIRST_PAGE)
                begin
                    first_page_reg <= cfg_data;
                end
                else if (cfg_index == REG_PAGE_COUNT)
                begin
                    page_count_reg <= cfg_data;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode;
            page_reg <= page_number;
        end
        if (res_load)
        begin
            res_page_reg   <= res_page_c;
            res_status_reg <= res_status_c;
            res_count_reg  <= res_count_c;
        end
        if (out_load)
        begin
            result_page_reg <= res_page_reg;
            status_reg      <= res_status_reg;
            ref_count_reg   <= res_count_reg;
            free_count_reg  <= free_c[REG_W-1:0];
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign result_page = result_page_reg;
    assign status      = status_reg;
    assign ref_count   = ref_count_reg;
    assign free_count  = free_count_reg;

    // The RAM is never read and written in the same cycle by this sequencer.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_rd_en && ram_wr_en))
        else $error("count RAM read and write in the same cycle");

    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= CW'(MAX_PAGES))
        else $error("used page count exceeds the number of pages");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && (mode_reg == MODE_ALLOC) && (res_status_reg == ST_OK)
        |-> (res_count_reg == COUNT_W'(1)))
        else $error("successful allocation with a count other than one");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != S_IDLE) && (state_reg != S_CLEAR))
        else $error("accepted request did not start work");

endmodule

// ----- rtl/core/pra_ram.sv -----
// ----------------------------------------------------------------------------
// pra_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
